/* rtl/efp_pkg.sv */
package efp_pkg;

  // Parser phase. The first ten codes double as the field kind of a byte.
  typedef enum logic [3:0] {
    PH_PRE   = 4'd0,
    PH_DELIM = 4'd1,
    PH_DEST  = 4'd2,
    PH_SRC   = 4'd3,
    PH_LENH  = 4'd4,
    PH_LENL  = 4'd5,
    PH_PAY   = 4'd6,
    PH_PAD   = 4'd7,
    PH_FCS   = 4'd8,
    PH_IGN   = 4'd9,
    PH_HALT  = 4'd10
  } phase_t;

  // Field lengths fixed by the frame format.
  localparam logic [7:0] PREAMBLE_LEN = 8'd7;
  localparam logic [7:0] ADDR_LEN     = 8'd6;
  localparam logic [7:0] FCS_LEN      = 8'd4;

  // Configuration register indexes.
  localparam logic [7:0] REG_PREAMBLE  = 8'd0;
  localparam logic [7:0] REG_DELIMITER = 8'd1;
  localparam logic [7:0] REG_MIN_PAY   = 8'd2;
  localparam logic [7:0] REG_THRESHOLD = 8'd3;

  // Configuration reset values.
  localparam logic [7:0] PREAMBLE_RST  = 8'hAA;
  localparam logic [7:0] DELIMITER_RST = 8'hAB;
  localparam logic [7:0] MIN_PAY_RST   = 8'd46;
  localparam logic [8:0] THRESHOLD_RST = 9'd100;

  typedef struct packed {
    logic [7:0] preamble_byte;
    logic [7:0] delimiter_byte;
    logic [7:0] min_payload;
    logic [8:0] continue_threshold;
  } cfg_t;

  // Per-frame parser state.
  typedef struct packed {
    phase_t     phase;
    logic [7:0] offset_count;
    logic [7:0] stored_length;
    logic       final_seen;
  } parse_state_t;

  // Tag information for one byte, plus the frame counter advance request.
  typedef struct packed {
    logic [3:0] field_kind;
    logic [7:0] field_offset;
    logic [7:0] payload_length;
    logic       frame_end;
    logic       stream_end;
    logic       sync_error;
    logic       next_frame;
  } step_res_t;

endpackage

/* rtl/efp_in_if.sv */
interface efp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

/* rtl/efp_out_if.sv */
interface efp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [7:0]  byte_out;
  logic [7:0]  field_offset;
  logic [15:0] frame_number;
  logic [7:0]  payload_length;
  logic        frame_end;
  logic        stream_end;
  logic        sync_error;

  modport source (output valid, output field_kind, output byte_out, output field_offset,
                  output frame_number, output payload_length, output frame_end,
                  output stream_end, output sync_error, input ready);
  modport sink (input valid, input field_kind, input byte_out, input field_offset,
                input frame_number, input payload_length, input frame_end,
                input stream_end, input sync_error, output ready);
endinterface

/* rtl/efp_cfg_if.sv */
interface efp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] addr;
  logic [8:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

/* rtl/ethernet_frame_field_parser_unit.sv */
// A result appears on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the tagging logic sits between the parser
// state registers and a single output register, and a byte is accepted
// whenever that register is empty or is being emptied in the same cycle.
// Reset (synchronous, rst_n low) restores default configuration, the preamble
// phase, frame number one and an empty output register.
module ethernet_frame_field_parser_unit #(
  parameter int FRAME_COUNT_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  efp_in_if.sink    in_bus,
  efp_out_if.source out_bus,
  efp_cfg_if.sink   cfg_bus
);
  import efp_pkg::*;

  localparam logic [FRAME_COUNT_BITS-1:0] FRAME_MAX = '1;
  localparam logic [FRAME_COUNT_BITS-1:0] FRAME_ONE = FRAME_COUNT_BITS'(1);

  cfg_t                        cfg_r;
  parse_state_t                state_r;
  parse_state_t                state_nxt;
  step_res_t                   res;
  logic [FRAME_COUNT_BITS-1:0] frame_cnt_r;
  logic [FRAME_COUNT_BITS+15:0] frame_ext;
  logic                        in_acc;
  logic                        out_valid_r;
  step_res_t                   res_r;
  logic [7:0]                  byte_r;
  logic [15:0]                 frame_num_r;

  // Configuration writes are always taken.
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_byte      <= PREAMBLE_RST;
      cfg_r.delimiter_byte     <= DELIMITER_RST;
      cfg_r.min_payload        <= MIN_PAY_RST;
      cfg_r.continue_threshold <= THRESHOLD_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.addr)
        REG_PREAMBLE:  cfg_r.preamble_byte      <= cfg_bus.data[7:0];
        REG_DELIMITER: cfg_r.delimiter_byte     <= cfg_bus.data[7:0];
        REG_MIN_PAY:   cfg_r.min_payload        <= cfg_bus.data[7:0];
        REG_THRESHOLD: cfg_r.continue_threshold <= cfg_bus.data;
        default: begin
        end
      endcase
    end
  end

  // Per-byte tagging and next phase.
  efp_step u_step (
    .cur         (state_r),
    .cfg         (cfg_r),
    .stream_byte (in_bus.stream_byte),
    .nxt         (state_nxt),
    .res         (res)
  );

  // Accept a request when the output register is free or draining.
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_acc       = in_bus.valid && in_bus.ready;

  // Parser state and saturating frame counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= PH_PRE;
      state_r.offset_count  <= 8'd0;
      state_r.stored_length <= 8'd0;
      state_r.final_seen    <= 1'b0;
      frame_cnt_r           <= FRAME_ONE;
    end else if (in_acc) begin
      state_r <= state_nxt;
      if (res.next_frame && (frame_cnt_r != FRAME_MAX)) begin
        frame_cnt_r <= frame_cnt_r + FRAME_ONE;
      end
    end
  end

  // Frame number is the counter truncated or zero-extended to 16 bits.
  assign frame_ext = {16'd0, frame_cnt_r};

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r       <= res;
      byte_r      <= in_bus.stream_byte;
      frame_num_r <= frame_ext[15:0];
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.field_kind     = res_r.field_kind;
  assign out_bus.byte_out       = byte_r;
  assign out_bus.field_offset   = res_r.field_offset;
  assign out_bus.frame_number   = frame_num_r;
  assign out_bus.payload_length = res_r.payload_length;
  assign out_bus.frame_end      = res_r.frame_end;
  assign out_bus.stream_end     = res_r.stream_end;
  assign out_bus.sync_error     = res_r.sync_error;

`ifndef SYNTHESIS
  // A frame ends only on the last check-sequence byte.
  a_frame_end_fcs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.frame_end) |->
      (res_r.field_kind == 4'(PH_FCS)) && (res_r.field_offset == FCS_LEN - 8'd1))
    else $error("frame end outside the last check-sequence byte");

  // The stream ends only together with a frame end.
  a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.stream_end) |-> res_r.frame_end)
    else $error("stream end without frame end");

  // An accepted byte always produces a result in the next cycle.
  a_acc_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted byte produced no result");

  // Once halted, the parser stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_HALT) |=> (state_r.phase == PH_HALT))
    else $error("parser left the halted phase");
`endif

endmodule

/* rtl/efp_step.sv */
module efp_step (
  input  efp_pkg::parse_state_t cur,
  input  efp_pkg::cfg_t         cfg,
  input  logic [7:0]            stream_byte,
  output efp_pkg::parse_state_t nxt,
  output efp_pkg::step_res_t    res
);
  import efp_pkg::*;

  logic [8:0] off_inc;
  logic       pay_done;
  logic       pad_done;
  logic       fcs_done;
  logic       short_pay;
  logic       len_final;
  phase_t     after_len;

  // Shared counter arithmetic and compares.
  assign off_inc   = {1'b0, cur.offset_count} + 9'd1;
  assign pay_done  = off_inc >= {1'b0, cur.stored_length};
  assign pad_done  = ({2'b00, cur.stored_length} + {1'b0, off_inc}) >= {2'b00, cfg.min_payload};
  assign fcs_done  = off_inc >= {1'b0, FCS_LEN};
  assign short_pay = cur.stored_length < cfg.min_payload;
  assign len_final = {1'b0, stream_byte} < cfg.continue_threshold;

  // Phase after the length low byte.
  always_comb begin
    if (stream_byte != 8'd0) begin
      after_len = PH_PAY;
    end else if (cfg.min_payload != 8'd0) begin
      after_len = PH_PAD;
    end else begin
      after_len = PH_FCS;
    end
  end

  // Next-state logic.
  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_PRE: begin
        if (stream_byte != cfg.preamble_byte) begin
          nxt.phase        = PH_HALT;
          nxt.offset_count = 8'd0;
        end else if (off_inc >= {1'b0, PREAMBLE_LEN}) begin
          nxt.phase        = PH_DELIM;
          nxt.offset_count = 8'd0;
        end else begin
          nxt.offset_count = off_inc[7:0];
        end
      end
      PH_DELIM: begin
        nxt.phase        = (stream_byte != cfg.delimiter_byte) ? PH_HALT : PH_DEST;
        nxt.offset_count = 8'd0;
      end
      PH_DEST, PH_SRC: begin
        if (off_inc >= {1'b0, ADDR_LEN}) begin
          nxt.phase        = (cur.phase == PH_DEST) ? PH_SRC : PH_LENH;
          nxt.offset_count = 8'd0;
        end else begin
          nxt.offset_count = off_inc[7:0];
        end
      end
      PH_LENH: begin
        nxt.phase        = PH_LENL;
        nxt.offset_count = 8'd0;
      end
      PH_LENL: begin
        nxt.stored_length = stream_byte;
        nxt.final_seen    = len_final;
        nxt.offset_count  = 8'd0;
        nxt.phase         = after_len;
      end
      PH_PAY: begin
        if (pay_done) begin
          nxt.phase        = short_pay ? PH_PAD : PH_FCS;
          nxt.offset_count = 8'd0;
        end else begin
          nxt.offset_count = off_inc[7:0];
        end
      end
      PH_PAD: begin
        if (pad_done) begin
          nxt.phase        = PH_FCS;
          nxt.offset_count = 8'd0;
        end else begin
          nxt.offset_count = off_inc[7:0];
        end
      end
      PH_FCS: begin
        if (fcs_done) begin
          nxt.offset_count = 8'd0;
          if (cur.final_seen) begin
            nxt.phase = PH_IGN;
          end else begin
            // A new frame starts with cleared length and final flag.
            nxt.phase         = PH_PRE;
            nxt.stored_length = 8'd0;
            nxt.final_seen    = 1'b0;
          end
        end else begin
          nxt.offset_count = off_inc[7:0];
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  // Output tagging logic.
  always_comb begin
    res                = '0;
    res.field_kind     = PH_IGN;
    res.payload_length = cur.stored_length;
    case (cur.phase)
      PH_PRE: begin
        res.field_kind   = PH_PRE;
        res.field_offset = cur.offset_count;
        res.sync_error   = stream_byte != cfg.preamble_byte;
      end
      PH_DELIM: begin
        res.field_kind = PH_DELIM;
        res.sync_error = stream_byte != cfg.delimiter_byte;
      end
      PH_DEST, PH_SRC, PH_PAY, PH_PAD: begin
        res.field_kind   = cur.phase;
        res.field_offset = cur.offset_count;
      end
      PH_LENH: begin
        res.field_kind = PH_LENH;
      end
      PH_LENL: begin
        res.field_kind     = PH_LENL;
        res.payload_length = stream_byte;
      end
      PH_FCS: begin
        res.field_kind   = PH_FCS;
        res.field_offset = cur.offset_count;
        res.frame_end    = fcs_done;
        res.stream_end   = fcs_done && cur.final_seen;
        res.next_frame   = fcs_done && !cur.final_seen;
      end
      PH_HALT: begin
        res.sync_error = 1'b1;
      end
      default: begin
        res.field_kind = PH_IGN;
      end
    endcase
  end

endmodule
